[design/brf_pkg.sv]
package brf_pkg;

    // Ring capacity in bytes; the ring itself has SIZE+1 slots.
    localparam int SIZE   = 255;
    localparam int SLOTS  = SIZE + 1;
    localparam int PTR_W  = $clog2(SLOTS);
    localparam int CNT_W  = (PTR_W > 8) ? PTR_W + 1 : 9;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 3;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [OP_W-1:0]   t_op;

    localparam t_op OP_ENQ   = 3'd0;
    localparam t_op OP_DEQ   = 3'd1;
    localparam t_op OP_PEEK  = 3'd2;
    localparam t_op OP_ADV_W = 3'd3;
    localparam t_op OP_ADV_R = 3'd4;
    localparam t_op OP_CLEAR = 3'd5;

    typedef struct packed {
        t_byte used_count;
        t_byte free_count;
        t_byte direct_write_room;
        t_byte direct_read_run;
    } t_status;

    // Bytes held for a given pointer pair.
    function automatic t_cnt used_of(input t_ptr rp, input t_ptr wp);
        t_cnt u;
        if (rp <= wp) begin
            u = CNT_W'(wp) - CNT_W'(rp);
        end else begin
            u = CNT_W'(SLOTS) - CNT_W'(rp) + CNT_W'(wp);
        end
        return u;
    endfunction

    // Pointer advance, wrapping only past SIZE. step never exceeds SIZE.
    function automatic t_ptr wrap_add(input t_ptr p, input t_cnt step);
        t_cnt s;
        s = CNT_W'(p) + step;
        if (s > CNT_W'(SIZE)) begin
            s = s - CNT_W'(SLOTS);
        end
        return PTR_W'(s);
    endfunction

    function automatic t_cnt min_cnt(input t_cnt a, input t_cnt b);
        return (a < b) ? a : b;
    endfunction

endpackage

[design/brf_status.sv]
module brf_status
    import brf_pkg::*;
(
    input  t_ptr    i_rp,
    input  t_ptr    i_wp,
    output t_status o_status
);

    t_cnt used;
    t_cnt free_sp;
    t_cnt wr_tail;
    t_cnt rd_tail;

    always_comb begin
        used    = used_of(i_rp, i_wp);
        free_sp = CNT_W'(SIZE) - used;
        wr_tail = CNT_W'(SIZE) - CNT_W'(i_wp);
        rd_tail = CNT_W'(SIZE) - CNT_W'(i_rp);
        o_status.used_count        = BYTE_W'(used);
        o_status.free_count        = BYTE_W'(free_sp);
        o_status.direct_write_room = BYTE_W'(min_cnt(free_sp, wr_tail));
        o_status.direct_read_run   = BYTE_W'(min_cnt(used, rd_tail));
    end

endmodule

[design/byte_ring_fifo_top.sv]
// Byte ring FIFO: one operation per input beat, one result beat per operation.
// Input channel: i_in_valid / o_in_stall with i_operation, i_data_in,
// i_amount. Operations are enqueue, dequeue, peek at an offset from the
// front, advance write pointer, advance read pointer, and clear.
// Output channel: o_out_valid / i_out_stall carrying the byte read (dequeue,
// peek), the count done (zero when refused) and the fill status after the
// operation: used, free, and the contiguous write room and read run.
// Path: an accepted beat passes through the middle stage, then the output
// register. The byte memory is read at the accepting edge, and the output
// register loads when the middle stage moves on and the output is free.
// Throughput: one operation per cycle unless stalled. Pointers are updated
// at acceptance, so the next operation sees them at once; each operation
// touches the byte memory at most once, a write or a read, at a single port.
// Reset (synchronous, active low) zeroes both pointers and empties the
// pipeline; memory contents are not cleared, no clearing pass is needed.
// When the receiver stalls, the output register holds its beat, the middle
// stage fills, and then o_in_stall rises until the output drains.
module byte_ring_fifo_top
    import brf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_op   i_operation,
    input  t_byte i_data_in,
    input  t_byte i_amount,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_byte o_data_out,
    output t_byte o_done_count,
    output t_byte o_used_count,
    output t_byte o_free_count,
    output t_byte o_direct_write_room,
    output t_byte o_direct_read_run
);

    // byte store, one write or one read per cycle
    t_byte mem [SLOTS];

    // live pointers
    t_ptr  r_rp, n_rp;
    t_ptr  r_wp, n_wp;

    // middle stage: waits for memory read data
    logic  r_p_valid;
    logic  r_p_rd;
    t_byte r_p_done;
    t_ptr  r_p_rp;
    t_ptr  r_p_wp;
    t_byte r_rdata;

    // output register
    logic  r_o_valid;
    t_byte r_o_data;
    t_byte r_o_done;
    t_status r_o_status;

    // accept-side decode
    logic  in_acc;
    logic  p_adv;
    logic  mem_we;
    logic  mem_rd;
    t_ptr  rd_addr;
    t_cnt  done;
    t_cnt  used_c;
    t_cnt  free_c;
    t_cnt  amt;

    t_status p_status;

    // Middle stage moves on when the output register is empty or draining.
    assign p_adv      = r_p_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_p_valid && !p_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        used_c  = used_of(r_rp, r_wp);
        free_c  = CNT_W'(SIZE) - used_c;
        amt     = CNT_W'(i_amount);
        n_rp    = r_rp;
        n_wp    = r_wp;
        mem_we  = 1'b0;
        mem_rd  = 1'b0;
        rd_addr = r_rp;
        done    = '0;
        case (i_operation)
            OP_ENQ: begin
                if (free_c != '0) begin
                    mem_we = 1'b1;
                    n_wp   = wrap_add(r_wp, CNT_W'(1));
                    done   = CNT_W'(1);
                end
            end
            OP_DEQ: begin
                if (used_c != '0) begin
                    mem_rd = 1'b1;
                    n_rp   = wrap_add(r_rp, CNT_W'(1));
                    done   = CNT_W'(1);
                end
            end
            OP_PEEK: begin
                // offset must land on a held byte
                if (amt < used_c) begin
                    mem_rd  = 1'b1;
                    rd_addr = wrap_add(r_rp, amt);
                    done    = CNT_W'(1);
                end
            end
            OP_ADV_W: begin
                done = min_cnt(amt, free_c);
                n_wp = wrap_add(r_wp, done);
            end
            OP_ADV_R: begin
                done = min_cnt(amt, used_c);
                n_rp = wrap_add(r_rp, done);
            end
            OP_CLEAR: begin
                n_rp = '0;
                n_wp = '0;
            end
            default: begin
                // unused codes leave the state alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && mem_we) begin
            mem[r_wp] <= i_data_in;
        end
        if (in_acc && mem_rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp      <= '0;
            r_wp      <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_rp <= n_rp;
                r_wp <= n_wp;
            end
            if (in_acc) begin
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
            if (p_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_rd   <= mem_rd;
            r_p_done <= BYTE_W'(done);
            r_p_rp   <= n_rp;
            r_p_wp   <= n_wp;
        end
        if (p_adv) begin
            r_o_data   <= r_p_rd ? r_rdata : '0;
            r_o_done   <= r_p_done;
            r_o_status <= p_status;
        end
    end

    // status from the pointers left by the operation
    brf_status u_status (
        .i_rp     (r_p_rp),
        .i_wp     (r_p_wp),
        .o_status (p_status)
    );

    assign o_out_valid         = r_o_valid;
    assign o_data_out          = r_o_data;
    assign o_done_count        = r_o_done;
    assign o_used_count        = r_o_status.used_count;
    assign o_free_count        = r_o_status.free_count;
    assign o_direct_write_room = r_o_status.direct_write_room;
    assign o_direct_read_run   = r_o_status.direct_read_run;

endmodule

[design/brf_checker.sv]
module brf_checker
    import brf_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  o_in_stall,
    input t_op   i_operation,
    input t_byte i_data_in,
    input t_byte i_amount,
    input logic  o_out_valid,
    input logic  i_out_stall,
    input t_byte o_data_out,
    input t_byte o_done_count,
    input t_byte o_used_count,
    input t_byte o_free_count,
    input t_byte o_direct_write_room,
    input t_byte o_direct_read_run
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_out)
            && $stable(o_done_count) && $stable(o_used_count))
        else $error("result beat changed while stalled");

    // used plus free always equals the capacity
    a_fill_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> BYTE_W'(o_used_count + o_free_count) == BYTE_W'(SIZE))
        else $error("used and free do not add up to capacity");

    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_direct_write_room <= o_free_count)
        else $error("contiguous write room exceeds free space");

    a_rd_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_direct_read_run <= o_used_count)
        else $error("contiguous read run exceeds used space");

    // input side cannot be blocked while the output side is free flowing
    a_no_deadlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall && $past(!i_out_stall) |-> !o_in_stall)
        else $error("input stalled with output draining");

endmodule

bind byte_ring_fifo_top brf_checker u_brf_checker (.*);
